>>> design/cbse_pkg.sv
// ----------------------------------------------------------------------------
// cbse_pkg
// Shared types and constants of the cubic Bezier segment evaluator.
// ----------------------------------------------------------------------------
package cbse_pkg;

  localparam int NUM_POINTS_DEF   = 256;
  localparam int NUM_SEGMENTS_DEF = 256;

  localparam int COORD_W  = 32;          // Q16.16 coordinate
  localparam int IDX_W    = 8;           // index fields
  localparam int U_W      = 17;          // Q1.16 curve parameter, 1.0 included
  localparam int FRAC_W   = 16;
  localparam int NUM_AXES = 3;
  localparam int VEC_W    = NUM_AXES * COORD_W;
  localparam int LINK_W   = 2 * IDX_W;

  localparam logic [U_W-1:0] U_ONE = U_W'(1 << FRAC_W);

  typedef enum logic [2:0] {
    CMD_WR_POINT = 3'd0,
    CMD_WR_HEAD  = 3'd1,
    CMD_WR_TAIL  = 3'd2,
    CMD_WR_LINK  = 3'd3,
    CMD_EVAL     = 3'd4
  } cmd_e;

  // x in element 0, y in 1, z in 2
  typedef logic [NUM_AXES-1:0][COORD_W-1:0] vec3_t;

  // store strobes from the sequencer
  typedef struct packed {
    logic pt_we;   // point write
    logic hd_we;   // head anchor write
    logic tl_we;   // tail anchor write
    logic ln_we;   // link write
    logic seg_re;  // read link and both anchors of a segment
    logic pt_re;   // read head and tail points
  } st_ctl_t;

endpackage

>>> design/cbse_store.sv
// ----------------------------------------------------------------------------
// cbse_store
// Point, anchor and link memories with registered read data.
// ----------------------------------------------------------------------------
module cbse_store #(
  parameter int NUM_POINTS   = cbse_pkg::NUM_POINTS_DEF,
  parameter int NUM_SEGMENTS = cbse_pkg::NUM_SEGMENTS_DEF,
  localparam int PT_AW = $clog2(NUM_POINTS),
  localparam int SG_AW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1
) (
  input  logic                          clk_i,
  input  cbse_pkg::st_ctl_t             ctl_i,
  input  logic [PT_AW-1:0]              wr_pt_addr_i,
  input  logic [SG_AW-1:0]              seg_addr_i,
  input  cbse_pkg::vec3_t               wr_data_i,
  input  logic [cbse_pkg::LINK_W-1:0]   wr_link_i,
  input  logic [PT_AW-1:0]              rd_hd_addr_i,
  input  logic [PT_AW-1:0]              rd_tl_addr_i,
  output logic [cbse_pkg::LINK_W-1:0]   link_o,
  output cbse_pkg::vec3_t               anc_hd_o,
  output cbse_pkg::vec3_t               anc_tl_o,
  output cbse_pkg::vec3_t               pt_hd_o,
  output cbse_pkg::vec3_t               pt_tl_o
);

  logic [cbse_pkg::VEC_W-1:0]  point_mem [NUM_POINTS];
  logic [cbse_pkg::VEC_W-1:0]  anc_hd_mem [NUM_SEGMENTS];
  logic [cbse_pkg::VEC_W-1:0]  anc_tl_mem [NUM_SEGMENTS];
  logic [cbse_pkg::LINK_W-1:0] link_mem [NUM_SEGMENTS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.pt_we) begin
      point_mem[wr_pt_addr_i] <= wr_data_i;
    end
    if (ctl_i.pt_re) begin
      pt_hd_o <= point_mem[rd_hd_addr_i];
      pt_tl_o <= point_mem[rd_tl_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.hd_we) begin
      anc_hd_mem[seg_addr_i] <= wr_data_i;
    end
    if (ctl_i.seg_re) begin
      anc_hd_o <= anc_hd_mem[seg_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.tl_we) begin
      anc_tl_mem[seg_addr_i] <= wr_data_i;
    end
    if (ctl_i.seg_re) begin
      anc_tl_o <= anc_tl_mem[seg_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ln_we) begin
      link_mem[seg_addr_i] <= wr_link_i;
    end
    if (ctl_i.seg_re) begin
      link_o <= link_mem[seg_addr_i];
    end
  end

endmodule

>>> design/cubic_bezier_segment_evaluator.sv
// ----------------------------------------------------------------------------
// cubic_bezier_segment_evaluator
// Stores path points and segments, evaluates cubic Bezier positions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transaction carries a
//   command. Point, anchor and link writes leave the block ready, so
//   writes stream at one per cycle while no evaluate runs. An evaluate transaction
//   holds in_stall_o high while the block computes the position.
//   Output channel (out_valid_o / out_stall_i): one transaction per evaluate,
//   pos_x/y/z in Q16.16, saturated to 32 bits. Writes and unknown commands
//   give no output transaction.
//   Evaluate: after acceptance the block steps through link read, point read,
//   coefficient setup, nine multiplies and drain, then loads the result into
//   the output register and takes the next transaction. The single 38x18
//   multiplier is shared by the three Horner steps of all three axes. An
//   evaluate of a segment index out of range returns zeros.
//   Stall: the result sits in an output register; while it is stalled the
//   block still takes writes and starts the next evaluate, which then waits
//   in its final state until the register is free.
//   Reset: asynchronous, active low; the sequencer returns to idle and the
//   output goes invalid. Memory contents are undefined until written.
// ----------------------------------------------------------------------------
module cubic_bezier_segment_evaluator #(
  parameter int NUM_POINTS   = cbse_pkg::NUM_POINTS_DEF,
  parameter int NUM_SEGMENTS = cbse_pkg::NUM_SEGMENTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          cmd_i,
  input  logic [cbse_pkg::IDX_W-1:0]          index_i,
  input  logic signed [cbse_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [cbse_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [cbse_pkg::COORD_W-1:0] coord_z_i,
  input  logic [cbse_pkg::IDX_W-1:0]          head_index_i,
  input  logic [cbse_pkg::IDX_W-1:0]          tail_index_i,
  input  logic [cbse_pkg::U_W-1:0]            param_u_i,
  input  logic                                forward_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cbse_pkg::COORD_W-1:0] pos_x_o,
  output logic signed [cbse_pkg::COORD_W-1:0] pos_y_o,
  output logic signed [cbse_pkg::COORD_W-1:0] pos_z_o
);

  localparam int PT_AW   = $clog2(NUM_POINTS);
  localparam int SG_AW   = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int MAX_AW  = (PT_AW > SG_AW) ? PT_AW : SG_AW;
  // one spare bit so the index compare also holds the depth itself
  localparam int EXT_W   = 1 + ((MAX_AW > cbse_pkg::IDX_W) ? MAX_AW : cbse_pkg::IDX_W);
  localparam int CW      = cbse_pkg::COORD_W;
  // Horner operands stay below 2^37 in magnitude
  localparam int OP_W    = 38;
  localparam int MU_W    = cbse_pkg::U_W + 1;
  localparam int PROD_W  = OP_W + MU_W;
  localparam int SUM_W   = OP_W + 1;
  localparam int NAX     = cbse_pkg::NUM_AXES;

  localparam logic [1:0] LAST_LANE = 2'(NAX - 1);
  localparam logic [1:0] STEP_A    = 2'd0;   // t = u*a
  localparam logic [1:0] STEP_B    = 2'd1;   // t = u*(b + t)
  localparam logic [1:0] STEP_C    = 2'd2;   // t = u*(c + t), then p1 + t

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (cbse_pkg::FRAC_W - 1));
  localparam logic signed [SUM_W-1:0]  SAT_MAX  = SUM_W'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SUM_W-1:0]  SAT_MIN  = -SUM_W'({1'b1, {(CW-1){1'b0}}});

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LINK   = 6'b000010,
    ST_COEF   = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[CW-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  state_e     state_q, state_d;
  logic [1:0] lane_q, lane_d;
  logic [1:0] step_q, step_d;
  logic       mul_vld_q, mul_vld_d;
  logic [1:0] mul_lane_q;
  logic [1:0] mul_step_q;
  logic       out_vld_q, out_vld_d;

  // payload registers
  logic [cbse_pkg::U_W-1:0] u_q;
  logic                     fwd_q;
  logic                     hd_ok_q, tl_ok_q;
  logic signed [OP_W-1:0]   op_q [NAX];
  logic signed [OP_W-1:0]   b_q  [NAX];
  logic signed [OP_W-1:0]   c_q  [NAX];
  logic signed [CW-1:0]     p1_q [NAX];
  logic signed [CW-1:0]     res_q [NAX];
  logic signed [CW-1:0]     pos_q [NAX];
  logic signed [PROD_W-1:0] prod_q;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic             in_acc;
  logic             eval_go;
  logic [EXT_W-1:0] idx_ext;
  logic             seg_ok, pt_ok;
  logic             load_out;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign eval_go    = in_acc && (cmd_i == cbse_pkg::CMD_EVAL);
  assign idx_ext    = EXT_W'(index_i);
  assign seg_ok     = idx_ext < EXT_W'(NUM_SEGMENTS);
  assign pt_ok      = idx_ext < EXT_W'(NUM_POINTS);

  // ---------------------------------------------------------------------------
  // Stores
  // ---------------------------------------------------------------------------
  cbse_pkg::st_ctl_t            st_ctl;
  cbse_pkg::vec3_t              wr_data;
  logic [cbse_pkg::LINK_W-1:0]  link_rd;
  cbse_pkg::vec3_t              anc_hd, anc_tl, pt_hd, pt_tl;
  logic [EXT_W-1:0]             hd_ext, tl_ext;

  assign st_ctl.pt_we  = in_acc && (cmd_i == cbse_pkg::CMD_WR_POINT) && pt_ok;
  assign st_ctl.hd_we  = in_acc && (cmd_i == cbse_pkg::CMD_WR_HEAD) && seg_ok;
  assign st_ctl.tl_we  = in_acc && (cmd_i == cbse_pkg::CMD_WR_TAIL) && seg_ok;
  assign st_ctl.ln_we  = in_acc && (cmd_i == cbse_pkg::CMD_WR_LINK) && seg_ok;
  assign st_ctl.seg_re = eval_go;
  assign st_ctl.pt_re  = (state_q == ST_LINK);

  assign wr_data = {coord_z_i, coord_y_i, coord_x_i};

  // link word: head index in the low byte, tail index in the high byte
  assign hd_ext = EXT_W'(link_rd[cbse_pkg::IDX_W-1:0]);
  assign tl_ext = EXT_W'(link_rd[cbse_pkg::LINK_W-1:cbse_pkg::IDX_W]);

  cbse_store #(
    .NUM_POINTS   (NUM_POINTS),
    .NUM_SEGMENTS (NUM_SEGMENTS)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (st_ctl),
    .wr_pt_addr_i (idx_ext[PT_AW-1:0]),
    .seg_addr_i   (idx_ext[SG_AW-1:0]),
    .wr_data_i    (wr_data),
    .wr_link_i    ({tail_index_i, head_index_i}),
    .rd_hd_addr_i (hd_ext[PT_AW-1:0]),
    .rd_tl_addr_i (tl_ext[PT_AW-1:0]),
    .link_o       (link_rd),
    .anc_hd_o     (anc_hd),
    .anc_tl_o     (anc_tl),
    .pt_hd_o      (pt_hd),
    .pt_tl_o      (pt_tl)
  );

  // ---------------------------------------------------------------------------
  // Power-basis coefficients, all three axes at once (adders only)
  //   c = 3(k1 - p1), b = 3(k2 - k1) - c, a = p2 - p1 - c - b
  // ---------------------------------------------------------------------------
  logic signed [OP_W-1:0] cf_a [NAX];
  logic signed [OP_W-1:0] cf_b [NAX];
  logic signed [OP_W-1:0] cf_c [NAX];
  logic signed [CW-1:0]   cf_p1 [NAX];

  always_comb begin
    logic signed [CW-1:0]   ph, pt;
    logic signed [OP_W-1:0] p1, p2, k1, k2, d1, d2;
    for (int i = 0; i < NAX; i++) begin
      // a link to a point beyond the store reads that point as zero
      ph = hd_ok_q ? $signed(pt_hd[i]) : '0;
      pt = tl_ok_q ? $signed(pt_tl[i]) : '0;
      p1 = fwd_q ? OP_W'(ph) : OP_W'(pt);
      p2 = fwd_q ? OP_W'(pt) : OP_W'(ph);
      k1 = fwd_q ? OP_W'($signed(anc_hd[i])) : OP_W'($signed(anc_tl[i]));
      k2 = fwd_q ? OP_W'($signed(anc_tl[i])) : OP_W'($signed(anc_hd[i]));
      d1 = k1 - p1;
      d2 = k2 - k1;
      cf_c[i]  = d1 + (d1 <<< 1);
      cf_b[i]  = d2 + (d2 <<< 1) - cf_c[i];
      cf_a[i]  = p2 - p1 - cf_c[i] - cf_b[i];
      cf_p1[i] = fwd_q ? ph : pt;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier and rounding accumulate stage
  // ---------------------------------------------------------------------------
  logic signed [OP_W-1:0]   mul_a;
  logic signed [MU_W-1:0]   mul_u;
  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [OP_W-1:0]   t_rnd;
  logic signed [SUM_W-1:0]  fin_sum;

  assign mul_a  = op_q[lane_q];
  assign mul_u  = $signed({1'b0, u_q});
  assign prod_w = mul_a * mul_u;

  // round to nearest, ties up: floor((x + 2^15) / 2^16)
  assign prod_rnd = prod_q + RND_HALF;
  assign t_rnd    = prod_rnd[cbse_pkg::FRAC_W +: OP_W];
  assign fin_sum  = SUM_W'(p1_q[mul_lane_q]) + SUM_W'(t_rnd);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign load_out = (state_q == ST_FINISH) && (!out_vld_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    lane_d    = lane_q;
    step_d    = step_q;
    mul_vld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (eval_go) begin
          state_d = seg_ok ? ST_LINK : ST_FINISH;
        end
      end
      ST_LINK: begin
        state_d = ST_COEF;
      end
      ST_COEF: begin
        lane_d  = '0;
        step_d  = STEP_A;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        // lanes interleave so each accumulate lands before its next multiply
        mul_vld_d = 1'b1;
        if (lane_q == LAST_LANE) begin
          lane_d = '0;
          if (step_q == STEP_C) begin
            state_d = ST_DRAIN;
          end else begin
            step_d = step_q + 2'd1;
          end
        end else begin
          lane_d = lane_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      lane_q     <= '0;
      step_q     <= STEP_A;
      mul_vld_q  <= 1'b0;
      mul_lane_q <= '0;
      mul_step_q <= STEP_A;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      lane_q     <= lane_d;
      step_q     <= step_d;
      mul_vld_q  <= mul_vld_d;
      mul_lane_q <= lane_q;
      mul_step_q <= step_q;
      out_vld_q  <= out_vld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      u_q   <= (param_u_i > cbse_pkg::U_ONE) ? cbse_pkg::U_ONE : param_u_i;
      fwd_q <= forward_i;
      for (int i = 0; i < NAX; i++) begin
        res_q[i] <= '0;   // kept for a segment index out of range
      end
    end
    if (state_q == ST_LINK) begin
      hd_ok_q <= hd_ext < EXT_W'(NUM_POINTS);
      tl_ok_q <= tl_ext < EXT_W'(NUM_POINTS);
    end
    if (state_q == ST_COEF) begin
      for (int i = 0; i < NAX; i++) begin
        op_q[i] <= cf_a[i];
        b_q[i]  <= cf_b[i];
        c_q[i]  <= cf_c[i];
        p1_q[i] <= cf_p1[i];
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_w;
    end
    if (mul_vld_q) begin
      unique case (mul_step_q)
        STEP_A:  op_q[mul_lane_q]  <= b_q[mul_lane_q] + t_rnd;
        STEP_B:  op_q[mul_lane_q]  <= c_q[mul_lane_q] + t_rnd;
        STEP_C:  res_q[mul_lane_q] <= sat_coord(fin_sum);
        default: op_q[mul_lane_q]  <= op_q[mul_lane_q];
      endcase
    end
    if (load_out) begin
      for (int i = 0; i < NAX; i++) begin
        pos_q[i] <= res_q[i];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign pos_z_o     = pos_q[2];

endmodule

>>> design/cbse_chk.sv
// ----------------------------------------------------------------------------
// cbse_chk
// Port-level assertions for the cubic Bezier segment evaluator.
// ----------------------------------------------------------------------------
module cbse_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [2:0]                   cmd_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [cbse_pkg::COORD_W-1:0] pos_x_o,
  input logic [cbse_pkg::COORD_W-1:0] pos_y_o,
  input logic [cbse_pkg::COORD_W-1:0] pos_z_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // an evaluate transaction occupies the block
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == cbse_pkg::CMD_EVAL)) |=> in_stall_o)
    else $error("evaluate accepted but block ready next cycle");

  // writes and unknown commands never occupy the block
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i != cbse_pkg::CMD_EVAL)) |=> !in_stall_o)
    else $error("non-evaluate transaction stalled the input");

  // a result only appears at the end of an evaluation
  a_out_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an evaluation in progress");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(pos_x_o) && $stable(pos_y_o) && $stable(pos_z_o)))
    else $error("stalled result changed or dropped");

endmodule

bind cubic_bezier_segment_evaluator cbse_chk u_cbse_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pos_x_o     (pos_x_o),
  .pos_y_o     (pos_y_o),
  .pos_z_o     (pos_z_o)
);

>>> tb/cubic_bezier_segment_evaluator_checker.sv
// ----------------------------------------------------------------------------
// cubic_bezier_segment_evaluator_checker
// Watches both channels of the segment evaluator and mirrors its point,
// anchor and link stores. Each evaluate is predicted when it is accepted, and
// each position transaction is compared per axis against the oldest prediction.
// ----------------------------------------------------------------------------
module cubic_bezier_segment_evaluator_checker
  import cbse_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [2:0]                cmd_i,
  input  logic [IDX_W-1:0]          index_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic [IDX_W-1:0]          head_index_i,
  input  logic [IDX_W-1:0]          tail_index_i,
  input  logic [U_W-1:0]            param_u_i,
  input  logic                      forward_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] pos_z_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint POS_MAX = 64'sh0000_0000_7fff_ffff;
  localparam longint POS_MIN = -64'sh0000_0000_8000_0000;

  const string AXIS_TAG [NUM_AXES] = '{"x", "y", "z"};

  vec3_t            point_mem       [NUM_POINTS_DEF];
  vec3_t            head_anchor_mem [NUM_SEGMENTS_DEF];
  vec3_t            tail_anchor_mem [NUM_SEGMENTS_DEF];
  logic [IDX_W-1:0] link_head_mem   [NUM_SEGMENTS_DEF];
  logic [IDX_W-1:0] link_tail_mem   [NUM_SEGMENTS_DEF];

  vec3_t expected_pos_q [$];
  int    fails   = 0;
  int    checked = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  // divide by 2^16, nearest, ties up (arithmetic shift floors)
  function automatic longint q16_round(longint v);
    return (v + 64'sd32768) >>> FRAC_W;
  endfunction

  // power-basis Horner evaluation of one axis, saturated to 32 bits
  function automatic logic [COORD_W-1:0] bezier_axis(longint p1, longint k1,
                                                     longint k2, longint p2,
                                                     longint u);
    longint c, b, a, acc;
    c   = 3 * (k1 - p1);
    b   = 3 * (k2 - k1) - c;
    a   = p2 - p1 - c - b;
    acc = q16_round(a * u);
    acc = q16_round((b + acc) * u);
    acc = q16_round((c + acc) * u);
    acc = p1 + acc;
    if (acc > POS_MAX) acc = POS_MAX;
    if (acc < POS_MIN) acc = POS_MIN;
    return acc[COORD_W-1:0];
  endfunction

  function automatic vec3_t point_at(logic [IDX_W-1:0] p);
    return (p < NUM_POINTS_DEF) ? point_mem[p] : '0;
  endfunction

  function automatic vec3_t predict_position(logic [IDX_W-1:0] seg,
                                             logic [U_W-1:0] u_in, logic fwd);
    vec3_t  p_first, p_last, k_first, k_last, pos;
    longint u;
    if (seg >= NUM_SEGMENTS_DEF) return '0;
    u = (u_in > U_ONE) ? U_ONE : u_in;
    if (fwd) begin
      p_first = point_at(link_head_mem[seg]);
      p_last  = point_at(link_tail_mem[seg]);
      k_first = head_anchor_mem[seg];
      k_last  = tail_anchor_mem[seg];
    end else begin
      p_first = point_at(link_tail_mem[seg]);
      p_last  = point_at(link_head_mem[seg]);
      k_first = tail_anchor_mem[seg];
      k_last  = head_anchor_mem[seg];
    end
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      pos[ax] = bezier_axis($signed(p_first[ax]), $signed(k_first[ax]),
                            $signed(k_last[ax]), $signed(p_last[ax]), u);
    end
    return pos;
  endfunction

  always @(posedge clk_i) begin : watch
    vec3_t got, want;
    if (rst_ni) begin
      // results first: a result never belongs to an evaluate of this edge
      if (out_valid_i && !out_stall_i) begin
        got = {pos_z_i, pos_y_i, pos_x_i};
        if (expected_pos_q.size() == 0) begin
          fails++;
          $display("%t: position (%0d, %0d, %0d) with no evaluate outstanding",
                   $time, pos_x_i, pos_y_i, pos_z_i);
        end else begin
          want = expected_pos_q.pop_front();
          checked++;
          for (int ax = 0; ax < NUM_AXES; ax++) begin
            if (got[ax] !== want[ax]) begin
              fails++;
              $display("%t: pos_%s expected %0d, actual %0d", $time, AXIS_TAG[ax],
                       $signed(want[ax]), $signed(got[ax]));
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (cmd_i)
          CMD_WR_POINT:
            if (index_i < NUM_POINTS_DEF)
              point_mem[index_i] = {coord_z_i, coord_y_i, coord_x_i};
          CMD_WR_HEAD:
            if (index_i < NUM_SEGMENTS_DEF)
              head_anchor_mem[index_i] = {coord_z_i, coord_y_i, coord_x_i};
          CMD_WR_TAIL:
            if (index_i < NUM_SEGMENTS_DEF)
              tail_anchor_mem[index_i] = {coord_z_i, coord_y_i, coord_x_i};
          CMD_WR_LINK:
            if (index_i < NUM_SEGMENTS_DEF) begin
              link_head_mem[index_i] = head_index_i;
              link_tail_mem[index_i] = tail_index_i;
            end
          CMD_EVAL:
            expected_pos_q.push_back(predict_position(index_i, param_u_i, forward_i));
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_pos_q.size();
    checked_o    <= checked;
  end

endmodule

>>> tb/cubic_bezier_segment_evaluator_test.sv
// ----------------------------------------------------------------------------
// cubic_bezier_segment_evaluator_test
// Stimulus and verdict for the cubic Bezier segment evaluator. A directed
// opening hits coordinate and parameter extremes, both directions and the
// ignored commands. Random segment builds, evaluates and stray writes follow,
// with idle cycles on both channels. Checking is left to the checker module.
// ----------------------------------------------------------------------------
module cubic_bezier_segment_evaluator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbse_pkg::*;

  localparam int ITEM_TARGET    = 1100;  // writes plus evaluates
  localparam int IDLE_PCT       = 11;    // idle odds per transaction/cycle
  localparam int PAUSE_AT       = 450;   // full drain of results here
  localparam int CALM_FROM      = 600;   // no idling on either side ...
  localparam int CALM_TO        = 800;   // ... between these item counts
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transaction at all
  localparam int TAIL_CYCLES    = 30;    // quiet tail after the last result

  // command codes the block ignores
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [COORD_W-1:0] COORD_NEG = 32'hffff_ffff;  // -1 LSB
  localparam logic [U_W-1:0]     U_TOP     = '1;             // far above 1.0

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_stall_o;
  logic [2:0]                cmd_i        = CMD_WR_POINT;
  logic [IDX_W-1:0]          index_i      = '0;
  logic signed [COORD_W-1:0] coord_x_i    = '0;
  logic signed [COORD_W-1:0] coord_y_i    = '0;
  logic signed [COORD_W-1:0] coord_z_i    = '0;
  logic [IDX_W-1:0]          head_index_i = '0;
  logic [IDX_W-1:0]          tail_index_i = '0;
  logic [U_W-1:0]            param_u_i    = '0;
  logic                      forward_i    = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i  = 1'b0;
  logic signed [COORD_W-1:0] pos_x_o;
  logic signed [COORD_W-1:0] pos_y_o;
  logic signed [COORD_W-1:0] pos_z_o;

  int fail_count;
  int pending_results;
  int checked_results;

  // calm = stretch with no idling on either channel
  logic calm = 1'b0;
  int   quiet_cycles = 0;
  int   n_writes = 0, n_evals = 0, n_ignored = 0;

  // what the stores hold so far; evaluates only touch written entries
  bit               point_written [NUM_POINTS_DEF];
  bit               head_written  [NUM_SEGMENTS_DEF];
  bit               tail_written  [NUM_SEGMENTS_DEF];
  bit               link_written  [NUM_SEGMENTS_DEF];
  logic [IDX_W-1:0] link_head     [NUM_SEGMENTS_DEF];
  logic [IDX_W-1:0] link_tail     [NUM_SEGMENTS_DEF];

  cubic_bezier_segment_evaluator DUT (.*);

  cubic_bezier_segment_evaluator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .cmd_i        (cmd_i),
    .index_i      (index_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .head_index_i (head_index_i),
    .tail_index_i (tail_index_i),
    .param_u_i    (param_u_i),
    .forward_i    (forward_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pos_x_i      (pos_x_o),
    .pos_y_i      (pos_y_o),
    .pos_z_i      (pos_z_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .checked_o    (checked_results)
  );

  always #2 clk_i = ~clk_i;

  // receiver: random stalls, none during the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // watchdog: any cycle with no transaction on either channel counts
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%t: watchdog, no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // random field values
  // -------------------------------------------------------------------------
  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned pick = $urandom_range(99);
    if (pick < 4)  return COORD_MAX;
    if (pick < 8)  return COORD_MIN;
    if (pick < 10) return '0;
    if (pick < 12) return COORD_NEG;
    // modest values, within +/-128.0, keep the curves away from the rails
    if (pick < 50) return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
    return $urandom;
  endfunction

  function automatic vec3_t rand_vec();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  // endpoints, beyond 1.0 (clamped by the block) and the open interval
  function automatic logic [U_W-1:0] rand_u();
    int unsigned pick = $urandom_range(99);
    if (pick < 6)  return '0;
    if (pick < 12) return U_ONE;
    if (pick < 18) return $urandom_range(U_ONE + 1, U_TOP);
    return $urandom_range(0, U_ONE - 1);
  endfunction

  // first segment from a random start whose link, anchors and points are set
  function automatic int pick_ready();
    int s;
    int start = $urandom_range(NUM_SEGMENTS_DEF - 1);
    for (int k = 0; k < NUM_SEGMENTS_DEF; k++) begin
      s = (start + k) % NUM_SEGMENTS_DEF;
      if (head_written[s] && tail_written[s] && link_written[s] &&
          point_written[link_head[s]] && point_written[link_tail[s]]) return s;
    end
    return -1;
  endfunction

  // -------------------------------------------------------------------------
  // input channel driver; fields a command ignores still get random values
  // -------------------------------------------------------------------------
  task automatic push_item(input logic [2:0] cmd, input logic [IDX_W-1:0] idx,
                           input vec3_t xyz, input logic [IDX_W-1:0] hd,
                           input logic [IDX_W-1:0] tl, input logic [U_W-1:0] u,
                           input logic fwd);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    index_i      <= idx;
    coord_x_i    <= xyz[0];
    coord_y_i    <= xyz[1];
    coord_z_i    <= xyz[2];
    head_index_i <= hd;
    tail_index_i <= tl;
    param_u_i    <= u;
    forward_i    <= fwd;
    // payload holds until the transaction goes through
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic put_point(input logic [IDX_W-1:0] p, input vec3_t xyz);
    push_item(CMD_WR_POINT, p, xyz, $urandom, $urandom, $urandom, $urandom);
    point_written[p] = 1'b1;
    n_writes++;
  endtask

  task automatic put_anchor(input cmd_e which, input logic [IDX_W-1:0] s,
                            input vec3_t xyz);
    push_item(which, s, xyz, $urandom, $urandom, $urandom, $urandom);
    if (which == CMD_WR_HEAD) head_written[s] = 1'b1;
    else                      tail_written[s] = 1'b1;
    n_writes++;
  endtask

  task automatic put_link(input logic [IDX_W-1:0] s, input logic [IDX_W-1:0] hd,
                          input logic [IDX_W-1:0] tl);
    push_item(CMD_WR_LINK, s, rand_vec(), hd, tl, $urandom, $urandom);
    link_written[s] = 1'b1;
    link_head[s]    = hd;
    link_tail[s]    = tl;
    n_writes++;
  endtask

  task automatic eval_seg(input logic [IDX_W-1:0] s, input logic [U_W-1:0] u,
                          input logic fwd);
    push_item(CMD_EVAL, s, rand_vec(), $urandom, $urandom, u, fwd);
    n_evals++;
  endtask

  task automatic put_noise();
    push_item($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST), $urandom, rand_vec(),
              $urandom, $urandom, $urandom, $urandom);
    n_ignored++;
  endtask

  // complete segment: points (sometimes reused), anchors, link, then evaluates
  task automatic build_segment();
    logic [IDX_W-1:0] seg = $urandom;
    logic [IDX_W-1:0] hd  = $urandom;
    logic [IDX_W-1:0] tl  = $urandom;
    if (!point_written[hd] || $urandom_range(1)) put_point(hd, rand_vec());
    if (!point_written[tl] || $urandom_range(1)) put_point(tl, rand_vec());
    put_anchor(CMD_WR_HEAD, seg, rand_vec());
    put_anchor(CMD_WR_TAIL, seg, rand_vec());
    put_link(seg, hd, tl);
    repeat ($urandom_range(1, 3)) eval_seg(seg, rand_u(), $urandom_range(1));
  endtask

  // stop sending and wait for every predicted position to come back;
  // the extra edge lets the checker count an evaluate taken at this edge
  task automatic drain_pending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int          seg;
    int unsigned pick;
    bit          paused = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed: rails on every axis, both directions, u at its limits ---
    put_point(8'd0,   {32'h0, COORD_MIN, COORD_MAX});
    put_point(8'd255, {COORD_NEG, COORD_MAX, COORD_MIN});
    put_anchor(CMD_WR_HEAD, 8'd0, {COORD_MAX, COORD_MAX, COORD_MIN});
    put_anchor(CMD_WR_TAIL, 8'd0, {COORD_MIN, COORD_MIN, COORD_MAX});
    put_link(8'd0, 8'd0, 8'd255);
    eval_seg(8'd0, '0, 1'b1);            // u = 0 gives the head point
    eval_seg(8'd0, U_ONE, 1'b1);         // u = 1.0 gives the tail point
    eval_seg(8'd0, U_TOP, 1'b0);         // above 1.0, clamped, reverse
    eval_seg(8'd0, U_ONE >> 1, 1'b0);    // midpoint, reverse
    eval_seg(8'd0, 17'd1, 1'b1);         // smallest step off the head
    eval_seg(8'd0, U_ONE - 1, 1'b1);     // last step before the tail
    // degenerate segment: head and tail share one point
    put_point(8'd1, {32'hfffd_0000, 32'h0002_8000, 32'h0001_0000});
    put_anchor(CMD_WR_HEAD, 8'd255, {32'h0004_0000, 32'hffff_8000, 32'h0000_0001});
    put_anchor(CMD_WR_TAIL, 8'd255, {32'hfff0_0000, 32'h0010_0000, COORD_NEG});
    put_link(8'd255, 8'd1, 8'd1);
    eval_seg(8'd255, U_ONE - 1, 1'b1);
    eval_seg(8'd255, 17'd12345, 1'b0);
    // unknown commands: nothing comes back
    put_noise();
    put_noise();
    put_noise();
    // overwrite a point under a live segment, then re-evaluate
    put_point(8'd0, rand_vec());
    eval_seg(8'd0, rand_u(), 1'b1);

    // --- random: mostly well-formed segments with random content ---
    while (n_writes + n_evals < ITEM_TARGET) begin
      if (!paused && n_writes + n_evals >= PAUSE_AT) begin
        drain_pending();
        paused = 1'b1;
      end
      calm <= (n_writes + n_evals >= CALM_FROM) && (n_writes + n_evals < CALM_TO);
      pick = $urandom_range(99);
      if (pick < 25) begin
        build_segment();
      end else if (pick < 65) begin
        seg = pick_ready();
        if (seg < 0) build_segment();
        else         eval_seg(seg, rand_u(), $urandom_range(1));
      end else if (pick < 92) begin
        // stray single write; may leave a segment pointing at unwritten points
        case ($urandom_range(3))
          0:       put_point($urandom, rand_vec());
          1:       put_anchor(CMD_WR_HEAD, $urandom, rand_vec());
          2:       put_anchor(CMD_WR_TAIL, $urandom, rand_vec());
          default: put_link($urandom, $urandom, $urandom);
        endcase
      end else begin
        put_noise();
      end
    end

    // --- wind down: every position back, then a quiet tail ---
    drain_pending();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d store writes and %0d evaluates (%0d positions checked),",
             n_writes, n_evals, checked_results);
    $display("%0d ignored commands, one full drain mid-run and a stretch with no idling",
             n_ignored);
    if (fail_count == 0 && pending_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
